[rtl/core/scbs_pkg.sv]
// Package for the smallest containing box search block.
// Holds the transaction payload types, field widths, mode and status codes.
// No dependencies.
package scbs_pkg;

	// Table size used as the default for the top level
	localparam int DEFAULT_TABLE_DEPTH = 512;

	// Fixed field widths
	localparam int COORD_W     = 16;
	localparam int POINT_W     = 20;
	localparam int FRAC_W      = 4;
	localparam int BOX_INDEX_W = 9;
	localparam int BOX_SIZE_W  = 17;

	// Operation codes carried in the mode field
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]                  mode;
		logic signed [COORD_W-1:0]   first_x;
		logic signed [COORD_W-1:0]   first_y;
		logic signed [COORD_W-1:0]   first_z;
		logic signed [COORD_W-1:0]   second_x;
		logic signed [COORD_W-1:0]   second_y;
		logic signed [COORD_W-1:0]   second_z;
		logic                        box_kind;
		logic signed [POINT_W-1:0]   point_x;
		logic signed [POINT_W-1:0]   point_y;
		logic signed [POINT_W-1:0]   point_z;
		logic                        plain_only;
	} in_item_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [BOX_INDEX_W-1:0] box_index;
		logic [BOX_SIZE_W-1:0]  box_size;
	} out_item_t;

	// One stored box: ordered corners, kind and its precomputed x+y span
	typedef struct packed {
		logic signed [COORD_W-1:0] low_x;
		logic signed [COORD_W-1:0] low_y;
		logic signed [COORD_W-1:0] low_z;
		logic signed [COORD_W-1:0] high_x;
		logic signed [COORD_W-1:0] high_y;
		logic signed [COORD_W-1:0] high_z;
		logic                      kind;
		logic [BOX_SIZE_W-1:0]     span;
	} entry_t;

endpackage

[rtl/core/smallest_containing_box_search.sv]
// Smallest containing box search: box table in a single-port-write memory and a
// sequential scan that compares one stored box per cycle. Depends on scbs_pkg.
//
// The block keeps a table of up to TABLE_DEPTH axis-aligned 3D boxes. A clear,
// an unused mode, an add on a full table or a query on an empty table goes
// straight to the response state; an add first writes the box, and a query
// scans all box_count entries and drains the read register. The scan reads
// one table entry per cycle through the memory's single registered read port
// and tests it against the point in one compare unit. Corners are stored
// ordered, with the x plus y span computed once when the box is written. Input
// is taken only between transactions; a finished result sits in an output
// register until taken, and a later result waits while that register is full.
// The table memory is not cleared; only entries below the box count are scanned.
module smallest_containing_box_search #(
	parameter int TABLE_DEPTH = scbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scbs_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output scbs_pkg::out_item_t out_item
);
	import scbs_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_TAIL,
		ST_RESP
	} state_t;

	state_t          state_q;
	in_item_t        in_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   rd_idx_q;
	logic [IW-1:0]   rd_idx_s1;
	logic            rd_vld_s1;
	entry_t          rd_data_s1;
	logic [1:0]      res_status_q;
	logic [IW-1:0]   res_idx_q;
	logic [BOX_SIZE_W-1:0] res_size_q;
	logic            out_valid_q;
	out_item_t       out_q;

	entry_t          mem [TABLE_DEPTH];

	entry_t          new_entry;
	logic            wr_en;
	logic [IW-1:0]   wr_idx;
	logic [IW-1:0]   last_idx;
	logic            in_box;
	logic            take;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign wr_en    = (state_q == ST_ADD);
	assign wr_idx   = count_q[IW-1:0];
	assign last_idx = IW'(count_q - CW'(1));

	// Order each corner pair and compute the x+y span of the new box
	always_comb begin
		new_entry.low_x  = (in_q.first_x < in_q.second_x) ? in_q.first_x : in_q.second_x;
		new_entry.high_x = (in_q.first_x < in_q.second_x) ? in_q.second_x : in_q.first_x;
		new_entry.low_y  = (in_q.first_y < in_q.second_y) ? in_q.first_y : in_q.second_y;
		new_entry.high_y = (in_q.first_y < in_q.second_y) ? in_q.second_y : in_q.first_y;
		new_entry.low_z  = (in_q.first_z < in_q.second_z) ? in_q.first_z : in_q.second_z;
		new_entry.high_z = (in_q.first_z < in_q.second_z) ? in_q.second_z : in_q.first_z;
		new_entry.kind   = in_q.box_kind;
		new_entry.span   = ({new_entry.high_x[COORD_W-1], new_entry.high_x}
			- {new_entry.low_x[COORD_W-1], new_entry.low_x})
			+ ({new_entry.high_y[COORD_W-1], new_entry.high_y}
			- {new_entry.low_y[COORD_W-1], new_entry.low_y});
	end

	// Test the entry read last cycle: inclusive containment on all three axes
	always_comb begin
		in_box = ($signed({rd_data_s1.low_x, {FRAC_W{1'b0}}}) <= in_q.point_x)
			&& ($signed({rd_data_s1.high_x, {FRAC_W{1'b0}}}) >= in_q.point_x)
			&& ($signed({rd_data_s1.low_y, {FRAC_W{1'b0}}}) <= in_q.point_y)
			&& ($signed({rd_data_s1.high_y, {FRAC_W{1'b0}}}) >= in_q.point_y)
			&& ($signed({rd_data_s1.low_z, {FRAC_W{1'b0}}}) <= in_q.point_z)
			&& ($signed({rd_data_s1.high_z, {FRAC_W{1'b0}}}) >= in_q.point_z);
		take = in_box && !(in_q.plain_only && rd_data_s1.kind)
			&& (rd_data_s1.span < res_size_q);
	end

	// Box table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= new_entry;
		end
		rd_data_s1 <= mem[rd_idx_q];
		rd_idx_s1  <= rd_idx_q;
	end

	// Sequencer, scan bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
			in_q         <= '0;
			res_status_q <= STATUS_OK;
			res_idx_q    <= '0;
			res_size_q   <= '0;
			out_q        <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);

			// Drop the output once taken, unless a new result replaces it
			if (out_valid_q && out_ready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end

			// Fold the entry read last cycle into the running best
			if (rd_vld_s1) begin
				if (rd_idx_s1 == '0) begin
					res_idx_q  <= '0;
					res_size_q <= rd_data_s1.span;
				end else if (take) begin
					res_idx_q  <= rd_idx_s1;
					res_size_q <= rd_data_s1.span;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						in_q         <= in_item;
						res_status_q <= STATUS_OK;
						res_idx_q    <= '0;
						res_size_q   <= '0;
						rd_idx_q     <= '0;
						unique case (in_item.mode)
							MODE_CLEAR: begin
								count_q <= '0;
								state_q <= ST_RESP;
							end
							MODE_ADD: begin
								if (count_q >= CW'(TABLE_DEPTH)) begin
									res_status_q <= STATUS_FULL;
									state_q      <= ST_RESP;
								end else begin
									state_q <= ST_ADD;
								end
							end
							MODE_QUERY: begin
								if (count_q == '0) begin
									res_status_q <= STATUS_EMPTY;
									state_q      <= ST_RESP;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_ADD: begin
					res_idx_q  <= wr_idx;
					res_size_q <= new_entry.span;
					count_q    <= count_q + CW'(1);
					state_q    <= ST_RESP;
				end
				ST_SCAN: begin
					// Advance the read address until the last valid entry
					if (rd_idx_q == last_idx) begin
						state_q <= ST_TAIL;
					end else begin
						rd_idx_q <= rd_idx_q + IW'(1);
					end
				end
				ST_TAIL: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					// Hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.status    <= res_status_q;
						out_q.box_index <= BOX_INDEX_W'(res_idx_q);
						out_q.box_size  <= res_size_q;
						out_valid_q     <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/smallest_containing_box_search_tb.sv]
`timescale 1ns / 1ps
// Testbench for smallest_containing_box_search: drives clear, add and query transactions,
// predicts each result in a scoreboard class and checks results in order.
// Depends on scbs_pkg and the smallest_containing_box_search RTL.
module smallest_containing_box_search_tb;
	import scbs_pkg::*;

	localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// a full-table query is the slowest transaction; allow it several times over
	localparam int WATCHDOG_LIMIT = 8 * (TABLE_DEPTH + 8);
	localparam int PHASE_END [4] = '{180, 360, 540, 1150};
	localparam int SEND_IDLE_PCT [4] = '{0, 83, 0, 37};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 83, 37};

	// Predicts results from its own copy of the box table and holds them in order
	class box_search_scoreboard;
		int lo_corner [TABLE_DEPTH][3];
		int hi_corner [TABLE_DEPTH][3];
		bit kind_bit [TABLE_DEPTH];
		int box_count;
		out_item_t pending_answers [$];
		int failures;

		function int span_of(int i);
			return (hi_corner[i][0] - lo_corner[i][0]) + (hi_corner[i][1] - lo_corner[i][1]);
		endfunction

		// Update the table and queue the result this transaction should produce
		function void note_request(in_item_t it);
			out_item_t answer;
			int first [3];
			int second [3];
			int pt [3];
			int best;
			int best_span;
			int s;
			bit hit;
			answer = '0;
			case (it.mode)
				MODE_CLEAR: box_count = 0;
				MODE_ADD: begin
					if (box_count >= TABLE_DEPTH) begin
						answer.status = STATUS_FULL;
					end else begin
						first[0] = it.first_x;
						first[1] = it.first_y;
						first[2] = it.first_z;
						second[0] = it.second_x;
						second[1] = it.second_y;
						second[2] = it.second_z;
						for (int a = 0; a < 3; a++) begin
							lo_corner[box_count][a] = first[a] < second[a] ? first[a] : second[a];
							hi_corner[box_count][a] = first[a] < second[a] ? second[a] : first[a];
						end
						kind_bit[box_count] = it.box_kind;
						s = span_of(box_count);
						best = box_count;
						answer.box_index = best[BOX_INDEX_W-1:0];
						answer.box_size = s[BOX_SIZE_W-1:0];
						box_count++;
					end
				end
				MODE_QUERY: begin
					if (box_count == 0) begin
						answer.status = STATUS_EMPTY;
					end else begin
						pt[0] = it.point_x;
						pt[1] = it.point_y;
						pt[2] = it.point_z;
						// entry 0 is the starting answer; strict less-than keeps the earlier on ties
						best = 0;
						best_span = span_of(0);
						for (int i = 0; i < box_count; i++) begin
							if (it.plain_only && kind_bit[i])
								continue;
							hit = 1'b1;
							for (int a = 0; a < 3; a++) begin
								if (lo_corner[i][a] * 16 > pt[a] || hi_corner[i][a] * 16 < pt[a])
									hit = 1'b0;
							end
							s = span_of(i);
							if (hit && s < best_span) begin
								best = i;
								best_span = s;
							end
						end
						answer.box_index = best[BOX_INDEX_W-1:0];
						answer.box_size = best_span[BOX_SIZE_W-1:0];
					end
				end
				default: ;
			endcase
			pending_answers.push_back(answer);
		endfunction

		// Compare a taken result with the oldest prediction
		function void check_response(out_item_t got);
			out_item_t want;
			if (pending_answers.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: status %0d index %0d size %0d",
						got.status, got.box_index, got.box_size);
				return;
			end
			want = pending_answers.pop_front();
			if (got.status !== want.status || got.box_index !== want.box_index ||
					got.box_size !== want.box_size) begin
				failures++;
				if (failures <= 10)
					$display("result mismatch: expected status %0d index %0d size %0d, got status %0d index %0d size %0d",
						want.status, want.box_index, want.box_size,
						got.status, got.box_index, got.box_size);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	box_search_scoreboard sb = new;
	int sent_items;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	smallest_containing_box_search #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Every bit of every field random; callers overwrite the fields that matter
	function automatic in_item_t random_fields();
		return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	// Present one transaction after a random idle gap and hold it until accepted
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(it);
		if (it.mode != MODE_UNUSED)
			sent_items++;
	endtask

	task automatic send_ctrl(input logic [1:0] mode);
		in_item_t it;
		it = random_fields();
		it.mode = mode;
		send_item(it);
	endtask

	task automatic send_box(input int x1, input int y1, input int z1,
			input int x2, input int y2, input int z2, input bit kind);
		in_item_t it;
		it = random_fields();
		it.mode = MODE_ADD;
		it.first_x = x1[15:0];
		it.first_y = y1[15:0];
		it.first_z = z1[15:0];
		it.second_x = x2[15:0];
		it.second_y = y2[15:0];
		it.second_z = z2[15:0];
		it.box_kind = kind;
		send_item(it);
	endtask

	task automatic send_query(input int px, input int py, input int pz, input bit plain);
		in_item_t it;
		it = random_fields();
		it.mode = MODE_QUERY;
		it.point_x = px[19:0];
		it.point_y = py[19:0];
		it.point_z = pz[19:0];
		it.plain_only = plain;
		send_item(it);
	endtask

	// Add a box: mostly clustered near the origin, some full range, extremes or copies
	task automatic add_random_box();
		int c [6];
		int sel;
		int j;
		sel = $urandom_range(9);
		for (int k = 0; k < 6; k++) begin
			if (sel <= 5)
				c[k] = int'($urandom_range(128)) - 64;
			else if (sel <= 7)
				c[k] = int'($urandom_range(65535)) - 32768;
			else
				c[k] = $urandom_range(1) ? 32767 : -32768;
		end
		if (sel == 9 && sb.box_count > 0) begin
			j = $urandom_range(sb.box_count - 1);
			for (int a = 0; a < 3; a++) begin
				if ($urandom_range(1)) begin
					c[a] = sb.lo_corner[j][a];
					c[a + 3] = sb.hi_corner[j][a];
				end else begin
					c[a] = sb.hi_corner[j][a];
					c[a + 3] = sb.lo_corner[j][a];
				end
			end
		end
		send_box(c[0], c[1], c[2], c[3], c[4], c[5], $urandom_range(1));
	endtask

	// Query a point: mostly aimed at a stored box, on its faces, inside or just outside
	task automatic query_random();
		int p [3];
		int sel;
		int j;
		int lo16;
		int hi16;
		sel = $urandom_range(9);
		j = 0;
		if (sb.box_count > 0)
			j = ($urandom_range(3) == 0) ? sb.box_count - 1 : $urandom_range(sb.box_count - 1);
		for (int a = 0; a < 3; a++) begin
			lo16 = sb.lo_corner[j][a] * 16;
			hi16 = sb.hi_corner[j][a] * 16;
			if (sel <= 5 && sb.box_count > 0) begin
				case ($urandom_range(7))
					0: p[a] = lo16;
					1: p[a] = hi16;
					2: p[a] = lo16 - 1;
					3: p[a] = hi16 + 1;
					default: p[a] = lo16 + int'($urandom_range(hi16 - lo16));
				endcase
			end else if (sel <= 7) begin
				p[a] = int'($urandom_range(2048)) - 1024;
			end else begin
				p[a] = int'($urandom_range(1048575)) - 524288;
			end
		end
		send_query(p[0], p[1], p[2], $urandom_range(1));
	endtask

	// One sequence: optional clear, a run of adds with queries mixed in, then queries
	task automatic run_episode();
		int n;
		if (sb.box_count > 200 || $urandom_range(9) < 6) begin
			send_ctrl(MODE_CLEAR);
			if ($urandom_range(9) == 0)
				query_random();
		end
		n = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(12, 1);
		repeat (n) begin
			add_random_box();
			if ($urandom_range(1))
				query_random();
			if ($urandom_range(39) == 0)
				send_ctrl(MODE_UNUSED);
		end
		repeat ($urandom_range(6, 1))
			query_random();
	endtask

	// Fill the table to the last entry, overflow it and query it at full size
	task automatic fill_table();
		send_ctrl(MODE_CLEAR);
		while (sb.box_count < TABLE_DEPTH - 1) begin
			add_random_box();
			if ($urandom_range(15) == 0)
				query_random();
		end
		send_box(30000, 30000, 30000, 30000, 30000, 30001, 1'b0);
		repeat (2)
			add_random_box();
		send_query(30000 * 16, 30000 * 16, 30000 * 16 + 8, 1'b1);
		repeat (6)
			query_random();
		send_ctrl(MODE_CLEAR);
	endtask

	// Take results with random stalls and check each one
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_response(out_item);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// End the run when no transaction moves for too long
	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, faces, ties, kind filter, zero span, clear
		send_query(0, 0, 0, 1'b0);
		send_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b1);
		send_query(-524288, -524288, -524288, 1'b1);
		send_query(524287, 524287, 524287, 1'b0);
		send_box(0, 0, 0, 1, 1, 1, 1'b0);
		send_query(16, 16, 16, 1'b0);
		send_query(17, 16, 16, 1'b0);
		send_box(1, 1, 1, 0, 0, 0, 1'b1);
		send_query(0, 0, 0, 1'b0);
		send_box(0, 0, -5, 0, 1, 5, 1'b1);
		send_query(0, 0, 0, 1'b1);
		send_query(0, 0, 0, 1'b0);
		send_box(0, 0, 0, 0, 0, 0, 1'b0);
		send_query(0, 0, 0, 1'b0);
		send_query(1, 0, 0, 1'b1);
		send_query(-1, -1, -1, 1'b0);
		send_ctrl(MODE_UNUSED);
		send_ctrl(MODE_CLEAR);
		send_query(5, 5, 5, 1'b0);
		send_box(-7, 3, 9, 2, -4, 9, 1'b0);
		send_query(-112, -64, 144, 1'b1);

		// Random sequences under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE_PCT[ph];
			recv_stall_pct = RECV_STALL_PCT[ph];
			if (ph == 3)
				fill_table();
			while (sent_items < PHASE_END[ph])
				run_episode();
		end
		in_valid <= 1'b0;

		// Drain, then watch for stray results
		while (sb.pending_answers.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (sb.failures == 0 && sb.pending_answers.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
